[sv/ttip_pkg.sv]
package ttip_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned CFG_W   = BASE_W;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

    localparam logic [VALUE_W-1:0] MAG_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] MAG_MAX_NEG = 64'h8000_0000_0000_0000;

    typedef enum logic {
        REG_NUMBER_BASE = 1'b0,
        REG_SIGNED_MODE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic               ok;
        logic               neg;
        logic               sgn;
        logic [VALUE_W-1:0] mag;
    } final_t;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

endpackage

[sv/text_to_integer_parser.sv]
// Text-to-integer parser. Words on the input channel carry one byte of a
// string (char_code) and a flag on its final byte (is_last). The string is
// parsed in the radix held in number_base, with an optional sign and range
// check when signed_mode is set. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while no string is in
// flight, as the block itself does not enforce it. One input word is taken
// in every cycle while in_ready is high: the digit multiply-add into the
// accumulator is a combinational 64 by 6 bit product.
// Only the final byte of a string produces an output word (parse_ok and
// parsed_value). The final-check stage, which applies the signed range check
// and negation, is loaded at the edge that takes that byte, and the output
// register from it once the output register is empty or its word is taken.
// When the receiver stalls, the output register holds its word and the
// final-check stage holds one more; once both are full, in_ready stays low
// for every byte until the output word is taken.
// Reset clears the parse state, restores number_base to 10 and signed_mode
// to 0, and empties both result stages.
module text_to_integer_parser
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [ttip_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ttip_pkg::CHAR_W-1:0]    char_code,
    input  logic                           is_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           parse_ok,
    output logic [ttip_pkg::VALUE_W-1:0]   parsed_value
);
    import ttip_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD      = 3'd0,
        PH_AFTERSIGN = 3'd1,
        PH_ZERO      = 3'd2,
        PH_PREFIX    = 3'd3,
        PH_DIGITS    = 3'd4,
        PH_TRAIL     = 3'd5
    } phase_t;

    logic [BASE_W-1:0]  number_base_reg;
    logic               signed_mode_reg;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [VALUE_W-1:0] mag_reg;
    logic [VALUE_W-1:0] mag_next;
    logic               neg_reg;
    logic               neg_next;
    logic               err_reg;
    logic               err_next;

    logic               fin_valid_reg;
    final_t             fin_reg;
    final_t             fin_next;
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic               out_ok_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [VALUE_W-1:0] out_value_next;

    logic               in_fire;
    logic               fin_move;
    logic               radix_ok;
    logic               is_space;
    logic               is_sign;
    logic               is_x;
    logic               d_ok;
    logic [BASE_W-1:0]  dval;
    logic [VALUE_W+BASE_W-1:0] prod;
    logic               ovf;

    assign fin_move  = fin_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !fin_valid_reg || fin_move;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign parse_ok  = out_ok_reg;
    assign parsed_value = out_value_reg;

    // Character classification and digit value.
    always_comb
    begin
        radix_ok = (number_base_reg >= BASE_MIN) && (number_base_reg <= BASE_MAX);
        is_space = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
        is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
        is_x     = (char_code == CH_LX) || (char_code == CH_UX);
        dval     = '0;
        d_ok     = 1'b0;
        if ((char_code >= CH_0) && (char_code <= CH_9))
        begin
            dval = BASE_W'(char_code - CH_0);
            d_ok = 1'b1;
        end
        else if ((char_code >= CH_LA) && (char_code <= CH_LZ))
        begin
            dval = BASE_W'(char_code - CH_LA + 8'd10);
            d_ok = 1'b1;
        end
        else if ((char_code >= CH_UA) && (char_code <= CH_UZ))
        begin
            dval = BASE_W'(char_code - CH_UA + 8'd10);
            d_ok = 1'b1;
        end
        d_ok = d_ok && radix_ok && (dval < number_base_reg);
        prod = (VALUE_W+BASE_W)'(mag_reg) * (VALUE_W+BASE_W)'(number_base_reg)
             + (VALUE_W+BASE_W)'(dval);
        ovf  = |prod[VALUE_W+BASE_W-1:VALUE_W];
    end

    // Parse state update for the byte on the input channel.
    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        err_next   = err_reg || !radix_ok;
        if (!err_next)
        begin
            case (phase_reg)
                PH_LEAD, PH_AFTERSIGN:
                begin
                    if (is_space)
                    begin
                        phase_next = phase_reg;
                    end
                    else if ((phase_reg == PH_LEAD) && signed_mode_reg && is_sign)
                    begin
                        neg_next   = (char_code == CH_MINUS);
                        phase_next = PH_AFTERSIGN;
                    end
                    else if (!d_ok)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        if (ovf)
                            err_next = 1'b1;
                        else
                            mag_next = prod[VALUE_W-1:0];
                        phase_next = ((number_base_reg == BASE_HEX) && (dval == '0))
                                   ? PH_ZERO : PH_DIGITS;
                    end
                end
                PH_ZERO:
                begin
                    if (is_x)
                        phase_next = PH_PREFIX;
                    else if (is_space)
                        phase_next = PH_TRAIL;
                    else if (!d_ok)
                        err_next = 1'b1;
                    else
                    begin
                        if (ovf)
                            err_next = 1'b1;
                        else
                            mag_next = prod[VALUE_W-1:0];
                        phase_next = PH_DIGITS;
                    end
                end
                PH_PREFIX, PH_DIGITS:
                begin
                    if ((phase_reg == PH_DIGITS) && is_space)
                        phase_next = PH_TRAIL;
                    else if (!d_ok)
                        err_next = 1'b1;
                    else
                    begin
                        if (ovf)
                            err_next = 1'b1;
                        else
                            mag_next = prod[VALUE_W-1:0];
                        phase_next = PH_DIGITS;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_space)
                        err_next = 1'b1;
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end

        fin_next.ok  = !err_next && ((phase_next == PH_ZERO) || (phase_next == PH_DIGITS)
                                  || (phase_next == PH_TRAIL));
        fin_next.neg = neg_next;
        fin_next.sgn = signed_mode_reg;
        fin_next.mag = mag_next;
    end

    // Signed range check and negation of a finished string.
    always_comb
    begin
        out_ok_next    = fin_reg.ok;
        out_value_next = fin_reg.mag;
        if (fin_reg.ok && fin_reg.sgn)
        begin
            if (fin_reg.neg)
            begin
                if (fin_reg.mag > MAG_MAX_NEG)
                    out_ok_next = 1'b0;
                else
                    out_value_next = '0 - fin_reg.mag;
            end
            else if (fin_reg.mag > MAG_MAX_POS)
            begin
                out_ok_next = 1'b0;
            end
        end
        if (!out_ok_next)
            out_value_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_RESET;
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_NUMBER_BASE: number_base_reg <= cfg_data;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:         number_base_reg <= number_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            err_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                if (is_last)
                begin
                    phase_reg <= PH_LEAD;
                    mag_reg   <= '0;
                    neg_reg   <= 1'b0;
                    err_reg   <= 1'b0;
                    fin_reg   <= fin_next;
                end
                else
                begin
                    phase_reg <= phase_next;
                    mag_reg   <= mag_next;
                    neg_reg   <= neg_next;
                    err_reg   <= err_next;
                end
            end

            if (in_fire && is_last)
                fin_valid_reg <= 1'b1;
            else if (fin_move)
                fin_valid_reg <= 1'b0;

            if (fin_move)
            begin
                out_valid_reg <= 1'b1;
                out_ok_reg    <= out_ok_next;
                out_value_reg <= out_value_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/ttip_checker.sv]
module ttip_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           is_last,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           parse_ok,
    input logic [ttip_pkg::VALUE_W-1:0]   parsed_value
);
    import ttip_pkg::*;

    // A stalled output word keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(parse_ok) && $stable(parsed_value))
        else $error("output word changed while stalled");

    // A failed parse always reports a zero value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_ok |-> parsed_value == '0)
        else $error("failed parse with non-zero value");

    // With the output register empty, the block never refuses a byte.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register empty");

    // A final byte taken while the output register is empty is followed by a valid output word.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_last && !out_valid |-> ##2 out_valid)
        else $error("result did not appear two cycles after final byte");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parse_ok     (parse_ok),
    .parsed_value (parsed_value)
);

[verif/text_parse_checker.sv]
module text_parse_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [ttip_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [ttip_pkg::CHAR_W-1:0]  char_code,
    input  logic                         is_last,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         parse_ok,
    input  logic [ttip_pkg::VALUE_W-1:0] parsed_value,
    output int                           faults,
    output int                           outstanding
);
    import ttip_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD      = 3'd0,
        PH_AFTERSIGN = 3'd1,
        PH_ZERO      = 3'd2,
        PH_PREFIX    = 3'd3,
        PH_DIGITS    = 3'd4,
        PH_TRAIL     = 3'd5
    } parse_phase_t;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } number_t;

    number_t            pending_numbers[$];
    logic [BASE_W-1:0]  radix;
    logic               signed_on;
    parse_phase_t       phase;
    logic [VALUE_W-1:0] magnitude;
    logic               negative;
    logic               failed;
    int                 fault_total;
    int                 results_seen;

    function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic int char_digit(input logic [CHAR_W-1:0] ch, input logic [BASE_W-1:0] r);
        int v;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            v = ch - CH_0;
        end
        else if (ch >= CH_LA && ch <= CH_LZ)
        begin
            v = ch - CH_LA + 10;
        end
        else if (ch >= CH_UA && ch <= CH_UZ)
        begin
            v = ch - CH_UA + 10;
        end
        else
        begin
            v = -1;
        end
        if (v >= int'(r))
        begin
            v = -1;
        end
        return v;
    endfunction

    // Overflow is exact: the product is formed wide and any bit above the low 64 fails the parse.
    task automatic add_digit(input int d);
        logic [VALUE_W+7:0] wide;
        wide = magnitude * radix + d;
        if (wide[VALUE_W+7:VALUE_W] != '0)
        begin
            failed = 1'b1;
        end
        else
        begin
            magnitude = wide[VALUE_W-1:0];
        end
    endtask

    task automatic absorb_char(input logic [CHAR_W-1:0] ch, input logic last);
        int      d;
        logic    blank;
        logic    radix_ok;
        number_t res;
        radix_ok = radix >= BASE_MIN && radix <= BASE_MAX;
        blank = is_blank(ch);
        d = radix_ok ? char_digit(ch, radix) : -1;
        if (!radix_ok)
        begin
            failed = 1'b1;
        end
        if (!failed)
        begin
            case (phase)
                PH_LEAD, PH_AFTERSIGN:
                begin
                    if (blank)
                    begin
                        phase = phase;
                    end
                    else if (phase == PH_LEAD && signed_on && (ch == CH_PLUS || ch == CH_MINUS))
                    begin
                        negative = ch == CH_MINUS;
                        phase = PH_AFTERSIGN;
                    end
                    else if (d < 0)
                    begin
                        failed = 1'b1;
                    end
                    else
                    begin
                        add_digit(d);
                        phase = (radix == BASE_HEX && d == 0) ? PH_ZERO : PH_DIGITS;
                    end
                end
                PH_ZERO:
                begin
                    if (ch == CH_LX || ch == CH_UX)
                    begin
                        phase = PH_PREFIX;
                    end
                    else if (blank)
                    begin
                        phase = PH_TRAIL;
                    end
                    else if (d < 0)
                    begin
                        failed = 1'b1;
                    end
                    else
                    begin
                        add_digit(d);
                        phase = PH_DIGITS;
                    end
                end
                PH_PREFIX, PH_DIGITS:
                begin
                    if (phase == PH_DIGITS && blank)
                    begin
                        phase = PH_TRAIL;
                    end
                    else if (d < 0)
                    begin
                        failed = 1'b1;
                    end
                    else
                    begin
                        add_digit(d);
                        phase = PH_DIGITS;
                    end
                end
                PH_TRAIL:
                begin
                    if (!blank)
                    begin
                        failed = 1'b1;
                    end
                end
                default:
                begin
                    failed = 1'b1;
                end
            endcase
        end
        if (last)
        begin
            res.ok = !failed && (phase == PH_ZERO || phase == PH_DIGITS || phase == PH_TRAIL);
            res.value = magnitude;
            if (res.ok && signed_on)
            begin
                if (negative)
                begin
                    if (magnitude > MAG_MAX_NEG)
                    begin
                        res.ok = 1'b0;
                    end
                    else
                    begin
                        res.value = -magnitude;
                    end
                end
                else if (magnitude > MAG_MAX_POS)
                begin
                    res.ok = 1'b0;
                end
            end
            if (!res.ok)
            begin
                res.value = '0;
            end
            pending_numbers.push_back(res);
            phase = PH_LEAD;
            magnitude = '0;
            negative = 1'b0;
            failed = 1'b0;
        end
    endtask

    task automatic note_fault(input string msg);
        fault_total++;
        if (fault_total <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        number_t want;
        if (!rst_n)
        begin
            radix = BASE_RESET;
            signed_on = 1'b0;
            phase = PH_LEAD;
            magnitude = '0;
            negative = 1'b0;
            failed = 1'b0;
            pending_numbers.delete();
            fault_total = 0;
            results_seen = 0;
            faults <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_numbers.size() == 0)
                begin
                    note_fault($sformatf(
                        "result word %0d arrived with none outstanding: ok=%0b value=%h",
                        results_seen, parse_ok, parsed_value));
                end
                else
                begin
                    want = pending_numbers.pop_front();
                    if (want.ok !== parse_ok || want.value !== parsed_value)
                    begin
                        note_fault($sformatf(
                            "result word %0d: expected ok=%0b value=%h, got ok=%0b value=%h",
                            results_seen, want.ok, want.value, parse_ok, parsed_value));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                absorb_char(char_code, is_last);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_NUMBER_BASE)
                begin
                    radix = cfg_data[BASE_W-1:0];
                end
                else
                begin
                    signed_on = cfg_data[0];
                end
            end
            faults <= fault_total;
            outstanding <= pending_numbers.size();
        end
    end

endmodule

[verif/text_to_integer_parser_tb.sv]
module text_to_integer_parser_tb;
    import ttip_pkg::*;

    localparam int ITEM_TARGET   = 1100;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 4;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [CHAR_W-1:0]   char_code;
    logic                is_last;
    logic                out_valid;
    logic                out_ready;
    logic                parse_ok;
    logic [VALUE_W-1:0]  parsed_value;
    int                  faults;
    int                  outstanding;

    logic [BASE_W-1:0]   cur_base;
    logic                cur_signed;
    bit                  steady;
    bit                  long_hold;
    int                  words_sent;
    int                  cycle_count = 0;
    logic [CHAR_W-1:0]   text[$];

    text_to_integer_parser uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parse_ok     (parse_ok),
        .parsed_value (parsed_value)
    );

    text_parse_checker watch
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parse_ok     (parse_ok),
        .parsed_value (parsed_value),
        .faults       (faults),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int digit_limit();
        return (cur_base >= BASE_MIN && cur_base <= BASE_MAX) ? int'(cur_base) : 36;
    endfunction

    task automatic push_space();
        int r;
        r = $urandom_range(0, 9);
        if (r > 4)
        begin
            text.push_back(CH_SPACE);
        end
        else
        begin
            text.push_back(CH_TAB + 8'(r));
        end
    endtask

    task automatic push_digit(input int v);
        if (v < 10)
        begin
            text.push_back(CH_0 + 8'(v));
        end
        else
        begin
            text.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10));
        end
    endtask

    task automatic push_sign();
        if (cur_signed ? $urandom_range(0, 3) != 0 : $urandom_range(0, 9) == 0)
        begin
            text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if ($urandom_range(0, 4) == 0)
            begin
                push_space();
            end
        end
    endtask

    task automatic push_prefix();
        if (cur_base == BASE_HEX && $urandom_range(0, 2) == 0)
        begin
            text.push_back(CH_0);
            text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        end
    endtask

    task automatic build_plain();
        int len;
        text.delete();
        if ($urandom_range(0, 1))
        begin
            repeat ($urandom_range(1, 3)) push_space();
        end
        push_sign();
        push_prefix();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 22) : $urandom_range(1, 4);
        repeat (len) push_digit($urandom_range(0, digit_limit() - 1));
        if ($urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 3)) push_space();
        end
    endtask

    // Values near the signed and unsigned 64-bit limits, or random, in cur_base (10 if bad).
    task automatic build_boundary();
        logic [VALUE_W:0] v;
        int               radix;
        int               ds[$];
        radix = (cur_base >= BASE_MIN && cur_base <= BASE_MAX) ? int'(cur_base) : 10;
        case ($urandom_range(0, 6))
            0: v = {1'b0, {VALUE_W{1'b1}}};
            1: v = {1'b1, {VALUE_W{1'b0}}};
            2: v = {1'b0, MAG_MAX_POS};
            3: v = {1'b0, MAG_MAX_NEG};
            4: v = {1'b0, MAG_MAX_NEG} + 65'd1;
            5: v = {1'b0, $urandom, $urandom} >> $urandom_range(0, 63);
            default: v = {1'b0, {VALUE_W{1'b1}}} - 65'($urandom_range(1, 3));
        endcase
        do
        begin
            ds.push_front(int'(v % radix));
            v = v / radix;
        end
        while (v != 0);
        text.delete();
        if ($urandom_range(0, 3) == 0)
        begin
            push_space();
        end
        push_sign();
        push_prefix();
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2)) text.push_back(CH_0);
        end
        foreach (ds[i])
        begin
            push_digit(ds[i]);
        end
    endtask

    task automatic build_broken();
        int pos;
        build_plain();
        pos = $urandom_range(0, text.size() - 1);
        if ($urandom_range(0, 1) && text.size() > 1)
        begin
            text.insert($urandom_range(1, text.size() - 1), CH_SPACE);
        end
        else
        begin
            text[pos] = CHAR_W'($urandom_range(0, 255));
        end
    endtask

    task automatic build_noise();
        text.delete();
        repeat ($urandom_range(1, 6)) text.push_back(CHAR_W'($urandom_range(0, 255)));
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= ch;
        is_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text();
        foreach (text[i])
        begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    // The block must have delivered every word and gone quiet before a register changes.
    task automatic write_config(input logic [BASE_W-1:0] base, input logic sgn);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_NUMBER_BASE;
        cfg_data <= CFG_W'(base);
        @(posedge clk);
        cfg_index <= REG_SIGNED_MODE;
        cfg_data <= CFG_W'(sgn);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_base = base;
        cur_signed = sgn;
    endtask

    initial
    begin
        int span;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            span = pick_gap();
            if (span > 0)
            begin
                out_ready <= 1'b0;
                repeat (span) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 4) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 8))
                @(posedge clk);
        end
    end

    initial
    begin
        int                kind;
        int                phase_count;
        logic [BASE_W-1:0] base_pick;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_NUMBER_BASE;
        cfg_data = '0;
        in_valid = 1'b0;
        char_code = '0;
        is_last = 1'b0;
        cur_base = BASE_RESET;
        cur_signed = 1'b0;
        steady = 1'b0;
        long_hold = 1'b0;
        words_sent = 0;
        phase_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        text = '{CH_0 + 8'd7};
        send_text();
        text = '{CH_MINUS, CH_0 + 8'd5};
        send_text();
        text = '{CH_TAB};
        send_text();
        text = '{8'hFF};
        send_text();
        write_config(BASE_HEX, 1'b1);
        text = '{CH_0, CH_LX};
        send_text();
        text = '{CH_MINUS, CH_0, CH_UX, CH_UA + 8'd5};
        send_text();
        text = '{CH_PLUS, CH_SPACE, CH_0};
        send_text();
        text = '{CH_MINUS, CH_0};
        send_text();
        text = '{CH_0 + 8'd1, CH_SPACE, CH_0 + 8'd2};
        send_text();
        write_config(BASE_MAX, 1'b0);
        text = '{CH_LZ, CH_UZ};
        send_text();
        write_config('0, 1'b0);
        text = '{CH_0 + 8'd1};
        send_text();

        while (words_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 11))
                0, 1: base_pick = BASE_MIN;
                2, 3: base_pick = BASE_MAX;
                4, 5: base_pick = BASE_HEX;
                6: base_pick = BASE_RESET;
                7: base_pick = $urandom_range(0, 1) ? '0 : '1;
                8: base_pick = $urandom_range(0, 1) ? BASE_MIN - 6'd1 : BASE_MAX + 6'd1;
                default: base_pick = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
            endcase
            write_config(base_pick, 1'($urandom_range(0, 1)));
            steady = $urandom_range(0, 3) == 0;
            if (phase_count == 1 || phase_count == 5)
            begin
                steady = 1'b1;
                long_hold = 1'b1;
            end
            repeat ($urandom_range(8, 20))
            begin
                if (words_sent < ITEM_TARGET)
                begin
                    kind = $urandom_range(0, 99);
                    if (kind < 50)
                    begin
                        build_plain();
                    end
                    else if (kind < 70)
                    begin
                        build_boundary();
                    end
                    else if (kind < 85)
                    begin
                        build_broken();
                    end
                    else
                    begin
                        build_noise();
                    end
                    send_text();
                end
            end
            phase_count++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (faults == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[text_to_integer_parser.f]
sv/ttip_pkg.sv
sv/text_to_integer_parser.sv
sv/ttip_checker.sv
verif/text_parse_checker.sv
verif/text_to_integer_parser_tb.sv
